// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked concurrent assertions, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define SMF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset
`define SMF_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== src/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the sliding median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

   // Sample and configuration widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int CSR_WIDTH    = 4;

   // Window size after reset
   localparam logic [CSR_WIDTH-1:0] WINDOW_RESET = 4'd3;

   // Input word
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           stream_end;
   } req_type;

   // Result word
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] median_value;
      logic                           run_last;
      logic                           stream_last;
   } rsp_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_NEXT,
      BACK_RANK
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/sliding_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_median_filter_core
// Streaming 1-D median filter with edge replication at both stream ends.
// Input channel req_*: one signed sample per word, stream_end on the last
// word of a stream. Result channel rsp_*: one median per sample, run_last on
// the last result a word causes, stream_last on the final result of a stream.
// csr_write_en/csr_write_data set the odd window size (reset value 3); write
// it only while the block is idle. An even, zero or too large size gives no
// results. Results start once a full window of samples has arrived; the last
// sample flushes the rest, so one word releases from zero up to MAX_WINDOW
// results. Each job is held in the queue; the back end handles each of its
// results in two steps, window gather into the tap registers, then rank
// select into the output register. A two-entry job queue lets the front
// keep taking samples while the back end works; when rsp_stall holds the
// output register, the back end and then the queue fill and req_stall
// rises. Synchronous reset empties the queue, drops any pending result and
// restarts the stream count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_median_filter_core #(
   parameter int MAX_WINDOW  = 9,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  smf_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output smf_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_en,
   input  logic [smf_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import smf_pkg::*;

   localparam int CW    = $clog2(MAX_WINDOW + 2);
   localparam int DW    = $clog2(MAX_WINDOW);
   localparam int JOB_W = MAX_WINDOW * SAMPLE_WIDTH + SAMPLE_WIDTH + CW + CSR_WIDTH
                          + 2 * DW + 1;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   logic [JOB_W-1:0] push_data;
   logic [JOB_W-1:0] head_data;

   smf_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .JOB_W      (JOB_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   smf_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (q_status),
      .head_data (head_data)
   );

   smf_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .JOB_W      (JOB_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== src/smf_queue.sv =====
// ----------------------------------------------------------------------------
// smf_queue
// Short register queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smf_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output smf_pkg::queue_status_type status,
   output logic [WIDTH-1:0]          head_data
);
   import smf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   // Gate the strobes with the fill level
   assign do_push = push && (count_ff != NW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   assign status.full  = (count_ff == NW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/smf_front.sv =====
// ----------------------------------------------------------------------------
// smf_front
// Takes samples, keeps the stream history and count, and turns each sample
// that releases outputs into a job naming the range of output positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smf_front #(
   parameter int MAX_WINDOW = 9,
   parameter int JOB_W      = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  smf_pkg::req_type                 req_payload,
   input  logic                             csr_write_en,
   input  logic [smf_pkg::CSR_WIDTH-1:0]    csr_write_data,
   input  smf_pkg::queue_status_type        q_status,
   output logic                             push,
   output logic [JOB_W-1:0]                 push_data
);
   import smf_pkg::*;

   localparam int CW   = $clog2(MAX_WINDOW + 2);
   localparam int DW   = $clog2(MAX_WINDOW);
   localparam int CMPW = (CW > CSR_WIDTH) ? CW : CSR_WIDTH;

   typedef struct packed {
      logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] hist;
      logic [SAMPLE_WIDTH-1:0]                 first_sample;
      logic [CW-1:0]                           seen;
      logic [CSR_WIDTH-1:0]                    window;
      logic [DW-1:0]                           d_hi;
      logic [DW-1:0]                           d_lo;
      logic                                    stream_end;
   } job_type;

   logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] hist_ff, hist_in, hist_shift;
   logic [SAMPLE_WIDTH-1:0]                 first_ff, first_in, first_new;
   logic [CW-1:0]                           seen_ff, seen_in, seen_step;
   logic [CSR_WIDTH-1:0]                    window_ff, window_in;
   logic                                    accept;
   logic                                    win_ok;
   logic                                    has_out;
   logic [CMPW-1:0]                         seen_cmp, win_cmp;
   logic [DW-1:0]                           half;
   job_type                                 job;

   assign accept    = req_valid && !q_status.full;
   assign req_stall = q_status.full;

   // Shift in the new word, newest at the bottom
   assign hist_shift = {hist_ff[MAX_WINDOW-2:0], req_payload.sample};
   assign first_new  = (seen_ff == '0) ? req_payload.sample : first_ff;
   assign seen_step  = (seen_ff < CW'(MAX_WINDOW + 1)) ? seen_ff + CW'(1) : seen_ff;

   always_comb begin
      hist_in   = accept ? hist_shift : hist_ff;
      first_in  = accept ? first_new : first_ff;
      seen_in   = seen_ff;
      if (accept) begin
         seen_in = req_payload.stream_end ? '0 : seen_step;
      end
      window_in = csr_write_en ? csr_write_data : window_ff;
   end

   // Classify: which output positions this word releases
   assign seen_cmp = CMPW'(seen_step);
   assign win_cmp  = CMPW'(window_ff);
   assign half     = DW'(window_ff >> 1);
   assign win_ok   = window_ff[0] && (win_cmp <= CMPW'(MAX_WINDOW));
   assign has_out  = win_ok && (seen_cmp >= win_cmp);

   always_comb begin
      job.hist         = hist_shift;
      job.first_sample = first_new;
      job.seen         = seen_step;
      job.window       = window_ff;
      job.d_hi         = (seen_cmp == win_cmp) ? DW'(window_ff - CSR_WIDTH'(1)) : half;
      job.d_lo         = req_payload.stream_end ? '0 : half;
      job.stream_end   = req_payload.stream_end;
   end

   assign push      = accept && has_out;
   assign push_data = JOB_W'(job);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         window_ff <= WINDOW_RESET;
      end else begin
         seen_ff   <= seen_in;
         window_ff <= window_in;
      end
   end

   // Hold history and the edge sample
   always_ff @(posedge clock) begin
      hist_ff  <= hist_in;
      first_ff <= first_in;
   end

endmodule

`default_nettype wire

// ===== src/smf_back.sv =====
// ----------------------------------------------------------------------------
// smf_back
// Walks the output positions of each job, gathers the edge-replicated
// window and picks the median by rank; each result is gathered, then ranked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smf_back #(
   parameter int MAX_WINDOW = 9,
   parameter int JOB_W      = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  smf_pkg::queue_status_type q_status,
   input  logic [JOB_W-1:0]          head_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output smf_pkg::rsp_type          rsp_payload
);
   import smf_pkg::*;

   localparam int CW   = $clog2(MAX_WINDOW + 2);
   localparam int DW   = $clog2(MAX_WINDOW);
   localparam int HMAX = MAX_WINDOW / 2;
   localparam int ELEN = 2 * MAX_WINDOW;
   localparam int SHW  = $clog2(ELEN);

   typedef struct packed {
      logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] hist;
      logic [SAMPLE_WIDTH-1:0]                 first_sample;
      logic [CW-1:0]                           seen;
      logic [CSR_WIDTH-1:0]                    window;
      logic [DW-1:0]                           d_hi;
      logic [DW-1:0]                           d_lo;
      logic                                    stream_end;
   } job_type;

   job_type                           job;
   back_state_type                    state_ff, state_in;
   logic [DW-1:0]                     d_ff, d_in, d_sel;
   logic [DW-1:0]                     half;
   logic [ELEN-1:0][SAMPLE_WIDTH-1:0] e_line;
   logic [ELEN*SAMPLE_WIDTH-1:0]      win_vec;
   logic [SHW-1:0]                    shamt;
   logic signed [SAMPLE_WIDTH-1:0]    win_ff [MAX_WINDOW];
   logic [DW-1:0]                     rank [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0]    median;
   logic                              load_win;
   logic                              out_free;
   logic                              out_load;
   logic                              run_end;
   logic                              rsp_valid_ff, rsp_valid_in;
   rsp_type                           rsp_payload_ff, rsp_payload_in;

   assign job  = job_type'(head_data);
   assign half = DW'(job.window >> 1);

   // Build the edge-replicated line: entry p holds the sample p - HMAX back
   for (genvar p = 0; p < ELEN; p++) begin : g_line
      if (p <= HMAX) begin : g_lead
         assign e_line[p] = job.hist[0];
      end else if (p - HMAX < MAX_WINDOW) begin : g_mid
         assign e_line[p] = (CW'(p - HMAX) < job.seen) ? job.hist[p - HMAX]
                                                       : job.first_sample;
      end else begin : g_tail
         assign e_line[p] = job.first_sample;
      end
   end

   // Slide the line so the window for position d starts at the bottom
   assign d_sel   = (state_ff == BACK_IDLE) ? job.d_hi : d_ff;
   assign shamt   = SHW'(d_sel) + SHW'(HMAX) - SHW'(half);
   assign win_vec = e_line >> (shamt * SAMPLE_WIDTH);

   // Rank each tap with ties broken by position; the one of rank half wins
   always_comb begin
      median = '0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         rank[k] = '0;
         for (int j = 0; j < MAX_WINDOW; j++) begin
            if (j < int'(job.window) &&
                ((win_ff[j] < win_ff[k]) || (win_ff[j] == win_ff[k] && j < k))) begin
               rank[k] = rank[k] + DW'(1);
            end
         end
      end
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (k < int'(job.window) && rank[k] == half) begin
            median = win_ff[k];
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign run_end  = (d_ff == job.d_lo);

   // Sequence gather and rank over the job's positions
   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      load_win = 1'b0;
      out_load = 1'b0;
      pop      = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               load_win = 1'b1;
               d_in     = job.d_hi;
               state_in = BACK_RANK;
            end
         end
         BACK_NEXT: begin
            load_win = 1'b1;
            state_in = BACK_RANK;
         end
         BACK_RANK: begin
            if (out_free) begin
               out_load = 1'b1;
               if (run_end) begin
                  pop      = 1'b1;
                  state_in = BACK_IDLE;
               end else begin
                  d_in     = d_ff - DW'(1);
                  state_in = BACK_NEXT;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Load the output register or drop the word once taken
   always_comb begin
      rsp_payload_in.median_value = median;
      rsp_payload_in.run_last     = run_end;
      rsp_payload_in.stream_last  = run_end && job.stream_end;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold position, window taps and result payload
   always_ff @(posedge clock) begin
      d_ff <= d_in;
      if (load_win) begin
         for (int k = 0; k < MAX_WINDOW; k++) begin
            win_ff[k] <= win_vec[k*SAMPLE_WIDTH +: SAMPLE_WIDTH];
         end
      end
      if (out_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== src/smf_checker.sv =====
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks on the result channel, bound to the filter top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module smf_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input smf_pkg::rsp_type rsp_payload
);
   import smf_pkg::*;

   // A stalled result stays offered
   `SMF_ASSERT(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "stalled result dropped")

   // A stalled result keeps its payload
   `SMF_ASSERT(a_rsp_hold_data, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_payload), "stalled payload changed")

   // The end of a stream always closes the current run
   `SMF_ASSERT(a_stream_closes_run, clock, reset, rsp_valid |-> (!rsp_payload.stream_last || rsp_payload.run_last), "stream_last without run_last")

   // Reset leaves no result pending
   `SMF_ASSERT_NORST(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind sliding_median_filter_core smf_checker u_smf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
